/* design/hkvm_pkg.sv */
// hkvm_pkg: request modes, status codes and the front-to-back command word
// no dependencies
`default_nettype none
package hkvm_pkg;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  localparam logic [MODE_W-1:0] MODE_PUT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GET = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEL = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REPLACED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd5;

  // classified request kind
  typedef enum logic [1:0] {
    OP_PUT  = 2'd0,
    OP_GET  = 2'd1,
    OP_DEL  = 2'd2,
    OP_NONE = 2'd3
  } op_t;
endpackage
`default_nettype wire

/* design/hkvm_if.sv */
// hkvm_if: valid/ready channel carrying request or result fields
// depends on hkvm_pkg
`default_nettype none
interface hkvm_req_if #(parameter int KEY_BITS = 64, parameter int VALUE_BITS = 32);
  logic                  valid;
  logic                  ready;
  logic [1:0]            mode;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;
  modport source (output valid, mode, key, value, input ready);
  modport sink (input valid, mode, key, value, output ready);
endinterface

interface hkvm_rsp_if #(parameter int VALUE_BITS = 32);
  logic                  valid;
  logic                  ready;
  logic [2:0]            status;
  logic [VALUE_BITS-1:0] value_out;
  logic [6:0]            entry_count;
  modport source (output valid, status, value_out, entry_count, input ready);
  modport sink (input valid, status, value_out, entry_count, output ready);
endinterface
`default_nettype wire

/* design/hkvm_ram.sv */
// hkvm_ram: generic single-port ram, registered read
// no dependencies
`default_nettype none
module hkvm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* design/hkvm_front.sv */
// hkvm_front: accepts requests, classifies the mode, two-entry command queue
// depends on hkvm_pkg
`default_nettype none
module hkvm_front #(
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  hkvm_req_if.sink                   req,
  output logic                       cmd_valid,
  input  wire logic                  cmd_ready,
  output hkvm_pkg::op_t              cmd_op,
  output logic [KEY_BITS-1:0]        cmd_key,
  output logic [VALUE_BITS-1:0]      cmd_value
);
  import hkvm_pkg::*;

  op_t                   q_op    [2];
  logic [KEY_BITS-1:0]   q_key   [2];
  logic [VALUE_BITS-1:0] q_value [2];
  logic                  wr_ptr, rd_ptr;
  logic [1:0]            fill;
  logic                  push, pop;
  op_t                   in_op;

  // mode decode
  always_comb begin
    case (req.mode)
      MODE_PUT: in_op = OP_PUT;
      MODE_GET: in_op = OP_GET;
      MODE_DEL: in_op = OP_DEL;
      default:  in_op = OP_NONE;
    endcase
  end

  assign req.ready = (fill != 2'd2);
  assign push      = req.valid && req.ready;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd_valid = (fill != 2'd0);
  assign cmd_op    = q_op[rd_ptr];
  assign cmd_key   = q_key[rd_ptr];
  assign cmd_value = q_value[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_op[wr_ptr]    <= in_op;
      q_key[wr_ptr]   <= req.key;
      q_value[wr_ptr] <= req.value;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

/* design/hkvm_back.sv */
// hkvm_back: walks the slots for a match, updates store, drives the result word
// depends on hkvm_pkg, hkvm_ram
`default_nettype none
module hkvm_back #(
  parameter int CAPACITY   = 64,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_ready,
  input  wire hkvm_pkg::op_t     cmd_op,
  input  wire logic [KEY_BITS-1:0]   cmd_key,
  input  wire logic [VALUE_BITS-1:0] cmd_value,
  hkvm_rsp_if.source             rsp,
  output logic [hkvm_pkg::COUNT_W-1:0] held_count
);
  import hkvm_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_CMP  = 5'b00100,
    S_ACT  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t                state;
  logic [CAPACITY-1:0]   valid_bits;
  logic [AW:0]           scan;
  logic [AW-1:0]         hit_slot;
  logic                  hit;
  logic [AW-1:0]         free_slot;
  logic                  has_free;
  logic [CW-1:0]         count;
  op_t                   op;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;

  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [KEY_BITS-1:0]   key_rd;
  logic [VALUE_BITS-1:0] val_rd;
  logic                  key_we;

  // lowest free slot, a priority encode over the valid flags
  always_comb begin
    free_slot = '0;
    has_free  = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!valid_bits[i]) begin
        free_slot = AW'(i);
        has_free  = 1'b1;
      end
    end
  end

  assign cmd_ready = (state == S_IDLE);

  // address mux: scan during search, target slot during update and for the get read
  always_comb begin
    ram_addr = scan[AW-1:0];
    ram_we   = 1'b0;
    key_we   = 1'b0;
    if (state == S_ACT && op == OP_PUT) begin
      if (hit) begin
        ram_addr = hit_slot;
        ram_we   = 1'b1;
      end else if (has_free) begin
        ram_addr = free_slot;
        ram_we   = 1'b1;
        key_we   = 1'b1;
      end
    end else if (state == S_ACT && op == OP_GET) begin
      ram_addr = hit_slot;
    end
  end

  hkvm_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_keys (
    .clk(clk), .we(key_we), .addr(ram_addr), .wdata(key), .rdata(key_rd)
  );
  hkvm_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_vals (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(value), .rdata(val_rd)
  );

  // sequencer: reads one slot at a time, compares on the registered word
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid_bits <= '0;
      count      <= '0;
      rsp.valid  <= 1'b0;
      hit        <= 1'b0;
      scan       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            op    <= cmd_op;
            key   <= cmd_key;
            value <= cmd_value;
            hit   <= 1'b0;
            scan  <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          // ram address is scan; data appears next cycle
          state <= S_CMP;
        end
        S_CMP: begin
          if (valid_bits[scan[AW-1:0]] && key_rd == key) begin
            hit      <= 1'b1;
            hit_slot <= scan[AW-1:0];
            state    <= S_ACT;
          end else if (scan == (AW+1)'(CAPACITY - 1)) begin
            state <= S_ACT;
          end else begin
            scan  <= scan + 1'b1;
            state <= S_READ;
          end
        end
        S_ACT: begin
          rsp.value_out <= '0;
          case (op)
            OP_PUT: begin
              if (hit) begin
                rsp.status <= ST_REPLACED;
              end else if (has_free) begin
                valid_bits[free_slot] <= 1'b1;
                count      <= count + 1'b1;
                rsp.status <= ST_INSERTED;
              end else begin
                rsp.status <= ST_FULL;
              end
            end
            OP_GET:  rsp.status <= hit ? ST_FOUND : ST_NOT_FOUND;
            OP_DEL: begin
              if (hit) begin
                valid_bits[hit_slot] <= 1'b0;
                count      <= count - 1'b1;
                rsp.status <= ST_REMOVED;
              end else begin
                rsp.status <= ST_NOT_FOUND;
              end
            end
            default: rsp.status <= ST_NOT_FOUND;
          endcase
          state <= S_OUT;
        end
        S_OUT: begin
          // get value read from hit slot lands now
          if (!rsp.valid) begin
            if (op == OP_GET && hit) rsp.value_out <= val_rd;
            rsp.valid <= 1'b1;
          end else if (rsp.ready) begin
            rsp.valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign held_count      = COUNT_W'(count);
  assign rsp.entry_count = COUNT_W'(count);
endmodule
`default_nettype wire

/* design/hashed_key_value_map_core.sv */
// hashed_key_value_map_core: top level, front classifier plus back executor
// depends on hkvm_pkg, hkvm_if, hkvm_front, hkvm_back
//
// channel  dir  signals
// req      in   valid ready mode key value
// rsp      out  valid ready status value_out entry_count
//
// a request walks the key ram from slot 0 up to the matching slot, or through all
// CAPACITY slots on a miss: each slot is read, then compared on the registered word,
// and the walk is framed by issue, update, result load and result hand-off
// reset: synchronous, clears valid flags, count and queue; no clearing pass
// the front queue holds two requests while the back waits on rsp.ready
`default_nettype none
module hashed_key_value_map_core #(
  parameter int CAPACITY   = 64,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32
) (
  input wire logic clk,
  input wire logic rst,
  hkvm_req_if.sink   req,
  hkvm_rsp_if.source rsp
);
  import hkvm_pkg::*;

  logic                  cmd_valid, cmd_ready;
  op_t                   cmd_op;
  logic [KEY_BITS-1:0]   cmd_key;
  logic [VALUE_BITS-1:0] cmd_value;
  logic [COUNT_W-1:0]    held_count;

  hkvm_front #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_front (
    .clk(clk), .rst(rst), .req(req),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .cmd_op(cmd_op), .cmd_key(cmd_key), .cmd_value(cmd_value)
  );

  hkvm_back #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS))
  u_back (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .cmd_op(cmd_op), .cmd_key(cmd_key), .cmd_value(cmd_value),
    .rsp(rsp), .held_count(held_count)
  );

`ifndef ASSERT_OFF
  // count never exceeds capacity
  a_count: assert property (@(posedge clk) disable iff (rst)
    held_count <= COUNT_W'(CAPACITY))
    else $error("entry count over capacity");
  // count changes only while no result is pending
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(held_count) |-> !rsp.valid)
    else $error("count moved while result pending");
  // a full status only with a full store
  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_FULL |-> held_count == COUNT_W'(CAPACITY))
    else $error("full status with free slots");
`endif
endmodule
`default_nettype wire
